FILE: hw/rtl/cs_pkg.sv
// Package with the types, constants and helper functions of the cosine similarity stream.
`timescale 1ns / 1ps
`default_nettype none
package cs_pkg;

	localparam int ELEM_W     = 16;
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int ACC_W      = 48;
	localparam int ROOT_W     = ACC_W / 2;
	localparam int SIM_W      = 16;
	localparam int QUO_W      = SIM_W - 1;
	localparam int DIV_CNT_W  = $clog2(QUO_W);
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [ACC_W-1:0] SQRT_BIT_INIT = ACC_W'(1) << (ACC_W - 2);
	localparam logic [QUO_W-1:0] QUO_MAX = {QUO_W{1'b1}};

	typedef struct packed {
		logic signed [ELEM_W-1:0] a_element;
		logic signed [ELEM_W-1:0] b_element;
		logic                     last;
	} cs_item_t;

	typedef struct packed {
		logic signed [SIM_W-1:0] similarity;
		logic                    degenerate;
	} cs_result_t;

	typedef struct packed {
		logic [ACC_W-1:0] dot;
		logic [ACC_W-1:0] first_norm;
		logic [ACC_W-1:0] second_norm;
	} cs_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cs_fifo_stat_t;

	typedef struct packed {
		logic [ACC_W-1:0] rem;
		logic [ACC_W-1:0] root;
	} cs_sqrt_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SQRT,
		CS_MUL,
		CS_CHK,
		CS_DIV,
		CS_DONE
	} cs_state_t;

	// One digit step of the bitwise integer square root.
	function automatic cs_sqrt_t cs_sqrt_step(input cs_sqrt_t cur, input logic [ACC_W-1:0] bitv);
		logic [ACC_W-1:0] trial;
		cs_sqrt_t nxt;
		trial = cur.root + bitv;
		if (cur.rem >= trial) begin
			nxt.rem  = cur.rem - trial;
			nxt.root = (cur.root >> 1) + bitv;
		end else begin
			nxt.rem  = cur.rem;
			nxt.root = cur.root >> 1;
		end
		return nxt;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cs_front.sv
// Front part: squares and products of each request, and the three running sums.
`timescale 1ns / 1ps
`default_nettype none
module cs_front
	import cs_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire cs_item_t      item,
	input  wire cs_fifo_stat_t fifo_stat,
	output logic               push,
	output cs_job_t            job
);

	logic                     valid_s1;
	logic                     last_s1;
	logic signed [PROD_W-1:0] ab_s1;
	logic        [PROD_W-1:0] aa_s1;
	logic        [PROD_W-1:0] bb_s1;
	logic        [ACC_W-1:0]  dot_q;
	logic        [ACC_W-1:0]  first_q;
	logic        [ACC_W-1:0]  second_q;
	logic        [ACC_W-1:0]  dot_next;
	logic        [ACC_W-1:0]  first_next;
	logic        [ACC_W-1:0]  second_next;
	logic signed [PROD_W-1:0] ab;
	logic signed [PROD_W-1:0] aa;
	logic signed [PROD_W-1:0] bb;
	logic                     advance;

	assign ab = PROD_W'(item.a_element) * PROD_W'(item.b_element);
	assign aa = PROD_W'(item.a_element) * PROD_W'(item.a_element);
	assign bb = PROD_W'(item.b_element) * PROD_W'(item.b_element);

	assign advance    = !(valid_s1 && last_s1 && fifo_stat.full);
	assign item_stall = !advance;

	assign dot_next    = dot_q + {{(ACC_W - PROD_W){ab_s1[PROD_W-1]}}, ab_s1};
	assign first_next  = first_q + {{(ACC_W - PROD_W){1'b0}}, aa_s1};
	assign second_next = second_q + {{(ACC_W - PROD_W){1'b0}}, bb_s1};

	assign push = valid_s1 && last_s1 && !fifo_stat.full;
	assign job  = '{dot: dot_next, first_norm: first_next, second_norm: second_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			dot_q    <= '0;
			first_q  <= '0;
			second_q <= '0;
		end else if (advance) begin
			valid_s1 <= item_valid;
			if (valid_s1) begin
				if (last_s1) begin
					dot_q    <= '0;
					first_q  <= '0;
					second_q <= '0;
				end else begin
					dot_q    <= dot_next;
					first_q  <= first_next;
					second_q <= second_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid) begin
			last_s1 <= item.last;
			ab_s1   <= ab;
			aa_s1   <= aa;
			bb_s1   <= bb;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/cs_fifo.sv
// Short queue of finished sums between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module cs_fifo
	import cs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire cs_job_t push_job,
	input  wire logic    pop,
	output cs_job_t      pop_job,
	output cs_fifo_stat_t stat
);

	cs_job_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [FIFO_CW-1:0]   cnt_q;

	assign stat.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_job    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/cs_back.sv
// Back part: square roots, root product, bounded division and the result register.
`timescale 1ns / 1ps
`default_nettype none
module cs_back
	import cs_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cs_fifo_stat_t fifo_stat,
	input  wire cs_job_t       pop_job,
	output logic               pop,
	output logic               result_valid,
	input  wire logic          result_stall,
	output cs_result_t         result
);

	cs_state_t              state_q;
	cs_state_t              state_next;
	logic                   result_valid_q;
	cs_result_t             result_q;
	cs_sqrt_t               sa_q;
	cs_sqrt_t               sb_q;
	logic [ACC_W-1:0]       bit_q;
	logic [ACC_W-1:0]       prod_q;
	logic [ACC_W-1:0]       rem_q;
	logic [QUO_W-1:0]       quo_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   neg_q;
	logic                   sat_q;
	logic                   degen_q;
	logic                   load_result;
	logic [ACC_W:0]         rem_shift;
	logic [ACC_W:0]         rem_diff;
	logic [QUO_W-1:0]       quo_final;
	logic [SIM_W-1:0]       mag16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next  = state_q;
		pop         = 1'b0;
		load_result = 1'b0;
		case (state_q)
			CS_IDLE: begin
				if (!fifo_stat.empty) begin
					pop        = 1'b1;
					state_next = CS_SQRT;
				end
			end
			CS_SQRT: begin
				if (bit_q[0]) begin
					state_next = CS_MUL;
				end
			end
			CS_MUL: begin
				state_next = CS_CHK;
			end
			CS_CHK: begin
				if (prod_q == '0 || rem_q >= prod_q) begin
					state_next = CS_DONE;
				end else begin
					state_next = CS_DIV;
				end
			end
			CS_DIV: begin
				if (cnt_q == '0) begin
					state_next = CS_DONE;
				end
			end
			CS_DONE: begin
				if (!result_valid_q || !result_stall) begin
					load_result = 1'b1;
					state_next  = CS_IDLE;
				end
			end
			default: begin
				state_next = CS_IDLE;
			end
		endcase
	end

	assign rem_shift = {rem_q, 1'b0};
	assign rem_diff  = rem_shift - {1'b0, prod_q};
	assign quo_final = sat_q ? QUO_MAX : quo_q;
	assign mag16     = {1'b0, quo_final};

	always_ff @(posedge clk) begin
		case (state_q)
			CS_IDLE: begin
				if (pop) begin
					sa_q    <= '{rem: pop_job.first_norm, root: '0};
					sb_q    <= '{rem: pop_job.second_norm, root: '0};
					bit_q   <= SQRT_BIT_INIT;
					neg_q   <= pop_job.dot[ACC_W-1];
					rem_q   <= pop_job.dot[ACC_W-1] ? (~pop_job.dot + 1'b1) : pop_job.dot;
				end
			end
			CS_SQRT: begin
				sa_q  <= cs_sqrt_step(sa_q, bit_q);
				sb_q  <= cs_sqrt_step(sb_q, bit_q);
				bit_q <= bit_q >> 2;
			end
			CS_MUL: begin
				prod_q <= {{(ACC_W - ROOT_W){1'b0}}, sa_q.root[ROOT_W-1:0]} *
					{{(ACC_W - ROOT_W){1'b0}}, sb_q.root[ROOT_W-1:0]};
			end
			CS_CHK: begin
				degen_q <= (prod_q == '0);
				sat_q   <= (rem_q >= prod_q);
				quo_q   <= '0;
				cnt_q   <= DIV_CNT_W'(QUO_W - 1);
			end
			CS_DIV: begin
				if (!rem_diff[ACC_W]) begin
					rem_q <= rem_diff[ACC_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_shift[ACC_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (load_result) begin
			result_q.degenerate <= degen_q;
			if (degen_q) begin
				result_q.similarity <= '0;
			end else if (neg_q) begin
				result_q.similarity <= -$signed(mag16);
			end else begin
				result_q.similarity <= $signed(mag16);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

FILE: hw/rtl/cosine_similarity_stream.sv
// Top level of the streaming cosine similarity block.
//
// Requests on the item channel carry one element pair of two Q1.15 vectors and a last
// flag. The front part takes one request per clock while no item stall is raised and
// keeps the dot product and both squared norms; the request marked last closes the
// vectors and hands the three sums to a two-entry queue. The back part takes sums from
// the queue, computes both integer square roots in 24 steps, multiplies the roots, and
// divides with one quotient bit per clock over 15 steps; if the root product is zero or
// no larger than the dot magnitude, it skips the division and the result is zero or
// saturated. It works on one set of sums at a time, so when it is slower than the front
// part the queue fills. An item stall is raised only while a last request waits for a
// free queue entry. The result sits in an output register; while the receiver stalls
// it holds, the back part waits with its next result, and the front part keeps taking
// items until the queue fills. Reset clears the sums, the queue and the result valid;
// no clearing pass is needed and requests are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none
module cosine_similarity_stream
	import cs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_stall,
	input  wire cs_item_t item,
	output logic          result_valid,
	input  wire logic     result_stall,
	output cs_result_t    result
);

	cs_fifo_stat_t fifo_stat;
	logic          push;
	logic          pop;
	cs_job_t       push_job;
	cs_job_t       pop_job;

	cs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.fifo_stat  (fifo_stat),
		.push       (push),
		.job        (push_job)
	);

	cs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.stat     (fifo_stat)
	);

	cs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_stat    (fifo_stat),
		.pop_job      (pop_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/cs_checker.sv
// Port checker for the cosine similarity stream and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cs_checker
	import cs_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_stall,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire cs_result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("Stalled result request changed.");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |-> result.similarity == '0)
		else $error("Degenerate result with nonzero similarity.");

	a_similarity_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.similarity != {1'b1, {(SIM_W - 1){1'b0}}})
		else $error("Similarity outside the saturated range.");

	// An item stall can only start right after a request was taken.
	a_stall_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(item_valid && !item_stall))
		else $error("Item stall raised without a preceding request.");

endmodule

bind cosine_similarity_stream cs_checker u_cs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire
